// ===== hdl/miq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// miq_pkg
// Shared types and codes for the middle insert queue.
// ----------------------------------------------------------------------------
package miq_pkg;

    localparam int VALUE_W          = 31;
    localparam int OCC_W            = 11;
    localparam int ACTION_W         = 2;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 1024;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MID  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RSVD = 2'd3;  // decoded as a pop

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_POPPED    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_PUSH_FULL = 2'd3;

    typedef enum logic [0:0] {
        S_IDLE,
        S_MOVE
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage : miq_pkg
`default_nettype wire

// ===== hdl/miq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// miq_ram
// Simple dual-port store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module miq_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 31,
    parameter int ADDR_W = 9
) (
    input  wire                   clk,
    input  miq_pkg::mem_ctl_t     ctl,
    input  wire  [ADDR_W-1:0]     wr_addr,
    input  wire  [WIDTH-1:0]      wr_data,
    input  wire  [ADDR_W-1:0]     rd_addr,
    output logic [WIDTH-1:0]      rd_data
);
    import miq_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : miq_ram
`default_nettype wire

// ===== hdl/miq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// miq_ctrl
// Ring pointers, counts and sequencer for the two half stores.
// ----------------------------------------------------------------------------
module miq_ctrl #(
    parameter int CAPACITY = miq_pkg::DEFAULT_CAPACITY
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [miq_pkg::ACTION_W-1:0]     action,
    input  wire  [miq_pkg::VALUE_W-1:0]      item_value,
    output logic                             done,
    output logic [miq_pkg::VALUE_W-1:0]      popped_value,
    output logic [miq_pkg::STATUS_W-1:0]     status,
    output logic [miq_pkg::OCC_W-1:0]        occupancy,
    output miq_pkg::mem_ctl_t                front_ctl,
    output logic [((((CAPACITY+1)/2) > 1) ? $clog2((CAPACITY+1)/2) : 1)-1:0] front_wr_addr,
    output logic [miq_pkg::VALUE_W-1:0]      front_wr_data,
    output logic [((((CAPACITY+1)/2) > 1) ? $clog2((CAPACITY+1)/2) : 1)-1:0] front_rd_addr,
    input  wire  [miq_pkg::VALUE_W-1:0]      front_rd_data,
    output miq_pkg::mem_ctl_t                back_ctl,
    output logic [((((CAPACITY+1)/2) > 1) ? $clog2((CAPACITY+1)/2) : 1)-1:0] back_wr_addr,
    output logic [miq_pkg::VALUE_W-1:0]      back_wr_data,
    output logic [((((CAPACITY+1)/2) > 1) ? $clog2((CAPACITY+1)/2) : 1)-1:0] back_rd_addr,
    input  wire  [miq_pkg::VALUE_W-1:0]      back_rd_data
);
    import miq_pkg::*;

    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int PTR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int N_W        = $clog2(CAPACITY + 1);

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      fh_reg, fh_next;
    logic [CNT_W-1:0]      fc_reg, fc_next;
    logic [PTR_W-1:0]      bh_reg, bh_next;
    logic [CNT_W-1:0]      bc_reg, bc_next;
    logic                  is_pop_reg, is_pop_next;
    logic                  move_reg, move_next;
    logic [PTR_W-1:0]      move_addr_reg, move_addr_next;
    logic                  done_reg, done_next;
    logic [VALUE_W-1:0]    popped_reg, popped_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;

    logic [N_W-1:0]        n;
    logic [N_W:0]          n_p2;
    logic [PTR_W-1:0]      front_tail;
    logic [PTR_W-1:0]      back_tail;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(head) + SUM_W'(count);
            if (sum >= SUM_W'(HALF_DEPTH))
            begin
                sum = sum - SUM_W'(HALF_DEPTH);
            end
            return sum[PTR_W-1:0];
        end
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            return (p == PTR_W'(HALF_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        begin
            return (p == '0) ? PTR_W'(HALF_DEPTH - 1) : p - PTR_W'(1);
        end
    endfunction

    assign n          = N_W'(fc_reg) + N_W'(bc_reg);
    assign n_p2       = {1'b0, n} + (N_W+1)'(2);
    assign front_tail = wrap_add(fh_reg, fc_reg);
    assign back_tail  = wrap_add(bh_reg, bc_reg);

    assign busy         = (state_reg == S_MOVE);
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fh_reg     <= '0;
            fc_reg     <= '0;
            bh_reg     <= '0;
            bc_reg     <= '0;
            is_pop_reg <= 1'b0;
            move_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fh_reg     <= fh_next;
            fc_reg     <= fc_next;
            bh_reg     <= bh_next;
            bc_reg     <= bc_next;
            is_pop_reg <= is_pop_next;
            move_reg   <= move_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        move_addr_reg <= move_addr_next;
        popped_reg    <= popped_next;
        status_reg    <= status_next;
        occ_reg       <= occ_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fh_next        = fh_reg;
        fc_next        = fc_reg;
        bh_next        = bh_reg;
        bc_next        = bc_reg;
        is_pop_next    = is_pop_reg;
        move_next      = move_reg;
        move_addr_next = move_addr_reg;
        done_next      = 1'b0;
        popped_next    = popped_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;

        front_ctl      = '0;
        front_wr_addr  = front_tail;
        front_wr_data  = item_value;
        front_rd_addr  = fh_reg;
        back_ctl       = '0;
        back_wr_addr   = back_tail;
        back_wr_data   = item_value;
        back_rd_addr   = bh_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    popped_next = '0;
                    is_pop_next = 1'b0;
                    move_next   = 1'b0;
                    if ((action == ACT_POP) || (action == ACT_RSVD))
                    begin
                        if (n == '0)
                        begin
                            status_next = STAT_POP_EMPTY;
                            occ_next    = OCC_W'(n);
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            // read the head now, hand it out from the move state
                            status_next     = STAT_POPPED;
                            occ_next        = OCC_W'(n) - OCC_W'(1);
                            front_ctl.rd_en = 1'b1;
                            fh_next         = ptr_inc(fh_reg);
                            fc_next         = fc_reg - CNT_W'(1);
                            is_pop_next     = 1'b1;
                            move_addr_next  = front_tail;
                            state_next      = S_MOVE;
                            // refill the front half from the back head
                            if ((N_W'(fc_reg) - N_W'(1) < (n >> 1)) && (bc_reg != '0))
                            begin
                                back_ctl.rd_en = 1'b1;
                                bh_next        = ptr_inc(bh_reg);
                                bc_next        = bc_reg - CNT_W'(1);
                                fc_next        = fc_reg;
                                move_next      = 1'b1;
                            end
                        end
                    end
                    else if (n >= N_W'(CAPACITY))
                    begin
                        status_next = STAT_PUSH_FULL;
                        occ_next    = OCC_W'(n);
                        done_next   = 1'b1;
                    end
                    else if (action == ACT_PUSH)
                    begin
                        status_next = STAT_INSERTED;
                        occ_next    = OCC_W'(n) + OCC_W'(1);
                        if ((N_W+1)'(fc_reg) < (n_p2 >> 1))
                        begin
                            fc_next = fc_reg + CNT_W'(1);
                            if (bc_reg == '0)
                            begin
                                // back half empty: the new value lands in front
                                front_ctl.wr_en = 1'b1;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                // append at back, move the back head to front
                                back_ctl.wr_en = 1'b1;
                                back_ctl.rd_en = 1'b1;
                                bh_next        = ptr_inc(bh_reg);
                                move_addr_next = front_tail;
                                move_next      = 1'b1;
                                state_next     = S_MOVE;
                            end
                        end
                        else
                        begin
                            back_ctl.wr_en = 1'b1;
                            bc_next        = bc_reg + CNT_W'(1);
                            done_next      = 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = STAT_INSERTED;
                        occ_next    = OCC_W'(n) + OCC_W'(1);
                        done_next   = 1'b1;
                        if (n[0] == 1'b0)
                        begin
                            front_ctl.wr_en = 1'b1;
                            fc_next         = fc_reg + CNT_W'(1);
                        end
                        else
                        begin
                            back_ctl.wr_en = 1'b1;
                            back_wr_addr   = ptr_dec(bh_reg);
                            bh_next        = ptr_dec(bh_reg);
                            bc_next        = bc_reg + CNT_W'(1);
                        end
                    end
                end
            end

            S_MOVE:
            begin
                // the move write is only live when the back head was read
                front_ctl.wr_en = move_reg;
                front_wr_addr   = move_addr_reg;
                front_wr_data   = back_rd_data;
                popped_next     = is_pop_reg ? front_rd_data : '0;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule : miq_ctrl
`default_nettype wire

// ===== hdl/middle_insert_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// middle_insert_queue
// FIFO of 31-bit values with push at tail, insert at middle and pop at head.
// ----------------------------------------------------------------------------
// Results: a push, middle insert or error beat is answered from the idle
//   state; a pop, or a push that moves an item between halves, passes
//   through the move state before its result is returned.
// Throughput: one item every cycle while busy is low; a pop or moving push
//   holds busy until the registered half-store read is back for the move write.
// Reset: asynchronous, clears pointers and counts; stores need no clearing.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module middle_insert_queue #(
    parameter int CAPACITY = miq_pkg::DEFAULT_CAPACITY
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire  [miq_pkg::ACTION_W-1:0]   action,
    input  wire  [miq_pkg::VALUE_W-1:0]    item_value,
    output logic                           done,
    output logic [miq_pkg::VALUE_W-1:0]    popped_value,
    output logic [miq_pkg::STATUS_W-1:0]   status,
    output logic [miq_pkg::OCC_W-1:0]      occupancy
);
    import miq_pkg::*;

    // The queue is split into two rings: the front half holds the first
    // ceil(n/2) items, the back half the rest, so the middle is the joint.
    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int PTR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;

    mem_ctl_t           front_ctl;
    logic [PTR_W-1:0]   front_wr_addr;
    logic [VALUE_W-1:0] front_wr_data;
    logic [PTR_W-1:0]   front_rd_addr;
    logic [VALUE_W-1:0] front_rd_data;
    mem_ctl_t           back_ctl;
    logic [PTR_W-1:0]   back_wr_addr;
    logic [VALUE_W-1:0] back_wr_data;
    logic [PTR_W-1:0]   back_rd_addr;
    logic [VALUE_W-1:0] back_rd_data;

    // Sequencer: decodes the beat, owns head pointers and counts, and
    // issues the store accesses; the move state finishes pops and moves.
    miq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .item_value    (item_value),
        .done          (done),
        .popped_value  (popped_value),
        .status        (status),
        .occupancy     (occupancy),
        .front_ctl     (front_ctl),
        .front_wr_addr (front_wr_addr),
        .front_wr_data (front_wr_data),
        .front_rd_addr (front_rd_addr),
        .front_rd_data (front_rd_data),
        .back_ctl      (back_ctl),
        .back_wr_addr  (back_wr_addr),
        .back_wr_data  (back_wr_data),
        .back_rd_addr  (back_rd_addr),
        .back_rd_data  (back_rd_data)
    );

    // Front half store: popped at head, filled at tail.
    miq_ram #(
        .DEPTH  (HALF_DEPTH),
        .WIDTH  (VALUE_W),
        .ADDR_W (PTR_W)
    ) u_front_ram (
        .clk     (clk),
        .ctl     (front_ctl),
        .wr_addr (front_wr_addr),
        .wr_data (front_wr_data),
        .rd_addr (front_rd_addr),
        .rd_data (front_rd_data)
    );

    // Back half store: filled at both ends, drained at head into the front.
    miq_ram #(
        .DEPTH  (HALF_DEPTH),
        .WIDTH  (VALUE_W),
        .ADDR_W (PTR_W)
    ) u_back_ram (
        .clk     (clk),
        .ctl     (back_ctl),
        .wr_addr (back_wr_addr),
        .wr_data (back_wr_data),
        .rd_addr (back_rd_addr),
        .rd_data (back_rd_data)
    );

endmodule : middle_insert_queue
`default_nettype wire

// ===== hdl/miq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// miq_checker
// Port-level checks on result timing and result contents.
// ----------------------------------------------------------------------------
module miq_checker #(
    parameter int CAPACITY = miq_pkg::DEFAULT_CAPACITY
) (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           start,
    input wire                           busy,
    input wire                           done,
    input wire [miq_pkg::VALUE_W-1:0]    popped_value,
    input wire [miq_pkg::STATUS_W-1:0]   status,
    input wire [miq_pkg::OCC_W-1:0]      occupancy
);
    import miq_pkg::*;

    // An accepted beat either answers next cycle or holds busy for it.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted beat neither answered nor held busy");

    // Busy lasts one cycle and ends with a result.
    a_busy_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("busy did not finish with a result");

    // A pop on an empty queue reports nothing held and no value.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_POP_EMPTY)) |-> ((occupancy == '0) && (popped_value == '0)))
        else $error("empty pop result inconsistent");

    // Only a good pop carries a value.
    a_value_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_POPPED)) |-> (popped_value == '0))
        else $error("value shown on a non-pop result");

    // A rejected push reports a full queue.
    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_PUSH_FULL)) |-> (occupancy == OCC_W'(CAPACITY)))
        else $error("push rejected while queue not full");

endmodule : miq_checker

bind middle_insert_queue miq_checker #(
    .CAPACITY (CAPACITY)
) u_miq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy)
);
`default_nettype wire
